@@ sv/bom_pkg.sv @@
// Shared types and constants of the battery over-discharge monitor.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package bom_pkg;

  localparam int VoltageBits = 13;
  localparam int DropBits    = 10;
  localparam int CountBits   = 4;
  localparam int CfgIdxBits  = 2;
  localparam int CfgDataBits = VoltageBits;

  localparam logic [VoltageBits-1:0] LowBatteryReset = VoltageBits'(3550);
  localparam logic [DropBits-1:0]    OveruseReset    = DropBits'(56);
  localparam logic [VoltageBits-1:0] WaitAboveReset  = VoltageBits'(4000);
  localparam logic [CountBits-1:0]   MaxInspReset    = CountBits'(10);

  typedef enum logic [1:0] {
    OpSample = 2'd0,
    OpEnter  = 2'd1,
    OpLeave  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    StRebase   = 2'd0,
    StOveruse  = 2'd1,
    StContinue = 2'd2,
    StStop     = 2'd3
  } status_e;

  typedef enum logic [CfgIdxBits-1:0] {
    RegLowBattery = 2'd0,
    RegOveruse    = 2'd1,
    RegWaitAbove  = 2'd2,
    RegMaxInsp    = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [VoltageBits-1:0] low_battery_mv;
    logic [DropBits-1:0]    overuse_drop_mv;
    logic [VoltageBits-1:0] wait_above_mv;
    logic [CountBits-1:0]   max_inspections;
  } cfg_t;

  typedef struct packed {
    logic                   monitor_active;
    logic [VoltageBits-1:0] baseline_mv;
    logic [CountBits-1:0]   judged_count;
    logic                   high_seen;
  } mon_state_t;

endpackage

@@ sv/bom_if.sv @@
// Valid/ready channel interfaces for monitor items and monitor results.
// Depends on bom_pkg for field widths.
`timescale 1ns / 1ps

interface bom_in_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      op;
  logic [bom_pkg::VoltageBits-1:0] voltage_mv;
  logic                            on_battery;

  modport source (output valid, output op, output voltage_mv, output on_battery,
                  input ready);
  modport sink   (input valid, input op, input voltage_mv, input on_battery,
                  output ready);
endinterface

interface bom_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    status;
  logic [bom_pkg::CountBits-1:0] sample_count;

  modport source (output valid, output status, output sample_count, input ready);
  modport sink   (input valid, input status, input sample_count, output ready);
endinterface

@@ sv/bom_judge.sv @@
// Next-state and status logic for one monitor word.
// Depends on bom_pkg for the state, configuration and code types.
`timescale 1ns / 1ps

module bom_judge (
  input  bom_pkg::cfg_t                   cfg_i,
  input  bom_pkg::mon_state_t             state_i,
  input  logic [1:0]                      op_i,
  input  logic [bom_pkg::VoltageBits-1:0] voltage_mv_i,
  input  logic                            on_battery_i,
  output bom_pkg::mon_state_t             state_o,
  output bom_pkg::status_e                status_o,
  output logic                            emit_o
);

  logic [bom_pkg::VoltageBits:0]   guard_sum;
  logic                            stop_guard;
  logic [bom_pkg::VoltageBits-1:0] drop;
  logic                            drop_hit;
  logic [bom_pkg::CountBits:0]     cnt_inc;
  logic                            limit_hit;
  logic                            under_limit;

  assign guard_sum   = {1'b0, cfg_i.low_battery_mv}
                     + (bom_pkg::VoltageBits+1)'(cfg_i.overuse_drop_mv);
  assign stop_guard  = guard_sum >= {1'b0, voltage_mv_i};
  assign drop        = state_i.baseline_mv - voltage_mv_i;
  assign drop_hit    = drop >= bom_pkg::VoltageBits'(cfg_i.overuse_drop_mv);
  assign cnt_inc     = {1'b0, state_i.judged_count} + (bom_pkg::CountBits+1)'(1);
  assign limit_hit   = cnt_inc >= {1'b0, cfg_i.max_inspections};
  assign under_limit = state_i.judged_count < cfg_i.max_inspections;

  always_comb begin
    state_o  = state_i;
    status_o = bom_pkg::StStop;
    emit_o   = 1'b0;
    unique case (op_i)
      bom_pkg::OpEnter: begin
        if (on_battery_i) begin
          state_o.monitor_active = 1'b1;
          state_o.baseline_mv    = '0;
          state_o.judged_count   = '0;
        end
      end
      bom_pkg::OpLeave: begin
        state_o.monitor_active = 1'b0;
        state_o.baseline_mv    = '0;
        state_o.judged_count   = '0;
      end
      bom_pkg::OpSample: begin
        emit_o = 1'b1;
        priority if (!state_i.monitor_active) begin
          status_o = bom_pkg::StStop;
        end else if (voltage_mv_i > state_i.baseline_mv) begin
          if (stop_guard) begin
            state_o.monitor_active = 1'b0;
            state_o.baseline_mv    = '0;
            state_o.judged_count   = '0;
            status_o               = bom_pkg::StStop;
          end else begin
            state_o.baseline_mv  = voltage_mv_i;
            state_o.judged_count = '0;
            status_o             = bom_pkg::StRebase;
          end
        end else if (voltage_mv_i <= cfg_i.wait_above_mv && state_i.high_seen) begin
          state_o.high_seen    = 1'b0;
          state_o.judged_count = '0;
          state_o.baseline_mv  = voltage_mv_i;
          status_o             = bom_pkg::StRebase;
        end else if (voltage_mv_i <= cfg_i.wait_above_mv && under_limit && drop_hit) begin
          state_o.monitor_active = 1'b0;
          state_o.baseline_mv    = '0;
          state_o.judged_count   = '0;
          status_o               = bom_pkg::StOveruse;
        end else if (limit_hit) begin
          if (voltage_mv_i > cfg_i.wait_above_mv) state_o.high_seen = 1'b1;
          state_o.monitor_active = 1'b0;
          state_o.baseline_mv    = '0;
          state_o.judged_count   = '0;
          status_o               = bom_pkg::StStop;
        end else begin
          if (voltage_mv_i > cfg_i.wait_above_mv) state_o.high_seen = 1'b1;
          state_o.judged_count = cnt_inc[bom_pkg::CountBits-1:0];
          status_o             = bom_pkg::StContinue;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ sv/battery_overdischarge_monitor.sv @@
// Battery over-discharge monitor top level: input register, judge logic, result register.
// Depends on bom_pkg, bom_if and bom_judge.
// Latency: a sample word passes the input register and then the result register before its result shows.
// Throughput: one word per cycle while results are taken; input ready follows result ready combinationally.
// Enter, leave and unused op words give no result but still pass through the judge stage.
// Reset: asynchronous, clears monitor state, pipeline valids and loads register defaults.
`timescale 1ns / 1ps

module battery_overdischarge_monitor (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  bom_in_if.sink                            in_i,
  bom_out_if.source                         out_o,
  input  logic                              cfg_we_i,
  input  logic [bom_pkg::CfgIdxBits-1:0]    cfg_idx_i,
  input  logic [bom_pkg::CfgDataBits-1:0]   cfg_data_i
);

  bom_pkg::cfg_t       cfg_q;
  bom_pkg::mon_state_t state_q, state_d;

  logic                            s1_valid_q;
  logic [1:0]                      s1_op_q;
  logic [bom_pkg::VoltageBits-1:0] s1_voltage_q;
  logic                            s1_batt_q;

  logic                            out_valid_q;
  bom_pkg::status_e                out_status_q;
  logic [bom_pkg::CountBits-1:0]   out_count_q;

  bom_pkg::status_e status;
  logic             emit;
  logic             advance;
  logic             in_accept;

  assign advance   = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || advance;
  assign in_accept = in_i.valid && in_i.ready;

  bom_judge u_judge (
    .cfg_i        (cfg_q),
    .state_i      (state_q),
    .op_i         (s1_op_q),
    .voltage_mv_i (s1_voltage_q),
    .on_battery_i (s1_batt_q),
    .state_o      (state_d),
    .status_o     (status),
    .emit_o       (emit)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_battery_mv  <= bom_pkg::LowBatteryReset;
      cfg_q.overuse_drop_mv <= bom_pkg::OveruseReset;
      cfg_q.wait_above_mv   <= bom_pkg::WaitAboveReset;
      cfg_q.max_inspections <= bom_pkg::MaxInspReset;
    end else if (cfg_we_i) begin
      unique case (bom_pkg::cfg_reg_e'(cfg_idx_i))
        bom_pkg::RegLowBattery:
          cfg_q.low_battery_mv  <= cfg_data_i[bom_pkg::VoltageBits-1:0];
        bom_pkg::RegOveruse:
          cfg_q.overuse_drop_mv <= cfg_data_i[bom_pkg::DropBits-1:0];
        bom_pkg::RegWaitAbove:
          cfg_q.wait_above_mv   <= cfg_data_i[bom_pkg::VoltageBits-1:0];
        bom_pkg::RegMaxInsp:
          cfg_q.max_inspections <= cfg_data_i[bom_pkg::CountBits-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        state_q <= state_d;
      end
      if (advance && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_op_q      <= in_i.op;
      s1_voltage_q <= in_i.voltage_mv;
      s1_batt_q    <= in_i.on_battery;
    end
    if (advance && emit) begin
      out_status_q <= status;
      out_count_q  <= state_q.judged_count;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = out_status_q;
  assign out_o.sample_count = out_count_q;

endmodule

@@ sv/bom_checker.sv @@
// Port-level checks on the battery over-discharge monitor, bound to its top level.
// Depends on bom_pkg for the status codes.
`timescale 1ns / 1ps

module bom_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [1:0]                    out_status_i,
  input logic [bom_pkg::CountBits-1:0] out_sample_count_i
);

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_status_i)
                                    && $stable(out_sample_count_i))
    else $error("result word changed while stalled");

  a_result_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !$past(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("result word without an accepted sample two cycles earlier");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled while the result register is empty");

  a_continue_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i == bom_pkg::StContinue |-> out_sample_count_i < 4'd14)
    else $error("continue reported at the inspection ceiling");

endmodule

bind battery_overdischarge_monitor bom_checker u_bom_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_i.valid),
  .in_ready_i         (in_i.ready),
  .out_valid_i        (out_o.valid),
  .out_ready_i        (out_o.ready),
  .out_status_i       (out_o.status),
  .out_sample_count_i (out_o.sample_count)
);
